>>> design/sorted_index_linked_list_insert_defines.svh
// Assertion macros shared by the sorted slot list modules.
`ifndef SORTED_INDEX_LINKED_LIST_INSERT_DEFINES_SVH
`define SORTED_INDEX_LINKED_LIST_INSERT_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SLLI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SLLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SLLI_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SLLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/slli_pkg.sv
// Shared types, constants and status codes of the sorted slot list.
package slli_pkg;

   // Table geometry and field widths.
   localparam int SLOTS_DEFAULT = 32;
   localparam int MAX_RESULTS = 32;
   localparam int LINK_W = 6;
   localparam int VALUE_W = 8;
   localparam int SLOT_W = 8;
   localparam int STATUS_W = 3;
   localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;
   localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'd100;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_VALUE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SLOT_USED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd5;

   // Request type codes.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READOUT = 1'b1;

   // Source of the table read address.
   typedef enum logic [1:0] {
      RD_HEAD,
      RD_LINK,
      RD_CUR
   } rd_sel_type;

   typedef struct packed {
      logic                req_type;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  item_value;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  out_value;
      logic [LINK_W-1:0]   out_slot;
      logic                last;
   } rsp_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load_req;
      logic                start_walk;
      logic                advance;
      logic                track;
      logic                write_entry;
      logic                write_prev;
      logic                emit;
      logic                emit_entry;
      logic [STATUS_W-1:0] status;
      logic                last;
      rd_sel_type          rd_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_readout;
      logic slot_bad;
      logic value_bad;
      logic head_valid;
      logic hit_slot;
      logic hit_value;
      logic next_valid;
      logic read_end;
      logic walk_end;
      logic prev_valid;
      logic out_free;
   } stat_type;

endpackage

>>> design/slli_ctrl.sv
// Controller state machine that sequences inserts and readouts.
`include "sorted_index_linked_list_insert_defines.svh"

module slli_ctrl
   import slli_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_WRITE,
      S_LINK,
      S_REPORT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A new beat is taken only between requests.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_CUR;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.rd_sel = RD_HEAD;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // Up-front checks while the head entry is read.
            cmd.rd_sel = RD_HEAD;
            cmd.start_walk = 1'b1;
            cmd.last = 1'b1;
            if (stat.is_readout) begin
               if (!stat.head_valid) begin
                  cmd.status = ST_EMPTY;
                  if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_WALK;
               end
            end else if (stat.slot_bad || stat.value_bad) begin
               cmd.status = stat.slot_bad ? ST_BAD_SLOT : ST_BAD_VALUE;
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (!stat.head_valid) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // One list entry per cycle; hold the entry while the output is busy.
            if (stat.is_readout) begin
               cmd.status = ST_OK;
               cmd.last = stat.read_end;
               cmd.emit_entry = 1'b1;
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  if (stat.read_end) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     cmd.rd_sel = RD_LINK;
                  end
               end
            end else if (stat.hit_slot || stat.hit_value) begin
               cmd.status = stat.hit_slot ? ST_SLOT_USED : ST_DUPLICATE;
               cmd.last = 1'b1;
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.track = 1'b1;
               if (!stat.next_valid || stat.walk_end) begin
                  state_in = S_WRITE;
               end else begin
                  cmd.advance = 1'b1;
                  cmd.rd_sel = RD_LINK;
               end
            end
         end
         S_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in = stat.prev_valid ? S_LINK : S_REPORT;
         end
         S_LINK: begin
            cmd.write_prev = 1'b1;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            cmd.status = ST_OK;
            cmd.last = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SLLI_ASSERT_NEXT(a_accept_check, clock, reset, req_valid && !req_stall,
      state_ff == S_CHECK, "accepted request did not enter the check state")
   `SLLI_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, stat.out_free,
      "result emitted while the output register was full")
   `SLLI_ASSERT_SAME(a_link_prev, clock, reset, cmd.write_prev, stat.prev_valid,
      "predecessor link written without a predecessor")

endmodule

>>> design/slli_dp.sv
// Datapath: slot tables, head pointer, walk registers and output register.
`include "sorted_index_linked_list_insert_defines.svh"

module slli_dp
   import slli_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  req_beat_type       req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [VALUE_W-1:0] csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_beat_type       rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int STEP_W = $clog2(SLOTS);
   localparam int READ_LIMIT = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;
   localparam logic [LINK_W-1:0] SLOTS_LINK = LINK_W'(SLOTS);
   localparam logic [SLOT_W-1:0] SLOTS_REQ = SLOT_W'(SLOTS);
   localparam logic [STEP_W-1:0] READ_LAST = STEP_W'(READ_LIMIT - 1);
   localparam logic [STEP_W-1:0] WALK_LAST = STEP_W'(SLOTS - 1);

   logic [VALUE_W-1:0] value_mem [SLOTS];
   logic [LINK_W-1:0]  link_mem [SLOTS];

   logic [VALUE_W-1:0] max_value_ff;
   logic [VALUE_W-1:0] max_value_in;
   logic [LINK_W-1:0]  head_ff;
   logic [LINK_W-1:0]  head_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   rsp_beat_type       out_data_ff;
   rsp_beat_type       out_data_in;
   req_beat_type       req_ff;
   logic [LINK_W-1:0]  cur_ff;
   logic [LINK_W-1:0]  prev_ff;
   logic [LINK_W-1:0]  prev_link_ff;
   logic               prev_valid_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [VALUE_W-1:0] value_rd_ff;
   logic [LINK_W-1:0]  link_rd_ff;

   logic [LINK_W-1:0]  rd_addr;
   logic [IDX_W-1:0]   rd_idx;
   logic [LINK_W-1:0]  req_slot;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   prev_idx;
   logic [LINK_W-1:0]  new_link;
   logic               is_less;

   // The register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   assign req_slot = req_ff.slot[LINK_W-1:0];
   assign req_idx = req_slot[IDX_W-1:0];
   assign prev_idx = prev_ff[IDX_W-1:0];
   assign new_link = prev_valid_ff ? prev_link_ff : head_ff;
   assign is_less = value_rd_ff < req_ff.item_value;

   // Table read address.
   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_ff;
         RD_LINK: rd_addr = link_rd_ff;
         RD_CUR:  rd_addr = cur_ff;
         default: rd_addr = head_ff;
      endcase
   end
   assign rd_idx = rd_addr[IDX_W-1:0];

   // Status toward the controller.
   always_comb begin
      stat.is_readout = (req_ff.req_type == REQ_READOUT);
      stat.slot_bad = (req_ff.slot >= SLOTS_REQ);
      stat.value_bad = (req_ff.item_value > max_value_ff);
      stat.head_valid = (head_ff < SLOTS_LINK);
      stat.hit_slot = (cur_ff == req_slot);
      stat.hit_value = (value_rd_ff == req_ff.item_value);
      stat.next_valid = (link_rd_ff < SLOTS_LINK);
      stat.read_end = !stat.next_valid || (step_ff == READ_LAST);
      stat.walk_end = (step_ff == WALK_LAST);
      stat.prev_valid = prev_valid_ff;
      stat.out_free = !out_valid_ff || !rsp_stall;
   end

   // Next values of the control registers.
   always_comb begin
      max_value_in = csr_valid ? csr_data : max_value_ff;
      head_in = head_ff;
      if (cmd.write_entry && !prev_valid_ff) begin
         head_in = req_slot;
      end
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      out_data_in.status = cmd.status;
      out_data_in.out_value = cmd.emit_entry ? value_rd_ff : '0;
      out_data_in.out_slot = cmd.emit_entry ? cur_ff : '0;
      out_data_in.last = cmd.last;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff <= MAX_VALUE_RESET;
         head_ff <= NULL_LINK;
         out_valid_ff <= 1'b0;
      end else begin
         max_value_ff <= max_value_in;
         head_ff <= head_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request, walk and output payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.start_walk) begin
         cur_ff <= head_ff;
         step_ff <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (cmd.advance) begin
            cur_ff <= link_rd_ff;
            step_ff <= step_ff + STEP_W'(1);
         end
         if (cmd.track && is_less) begin
            prev_ff <= cur_ff;
            prev_link_ff <= link_rd_ff;
            prev_valid_ff <= 1'b1;
         end
      end
      if (cmd.emit) begin
         out_data_ff <= out_data_in;
      end
   end

   // Slot tables: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         value_mem[req_idx] <= req_ff.item_value;
         link_mem[req_idx] <= new_link;
      end else if (cmd.write_prev) begin
         link_mem[prev_idx] <= req_slot;
      end
      value_rd_ff <= value_mem[rd_idx];
      link_rd_ff <= link_mem[rd_idx];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   `SLLI_ASSERT_SAME(a_head_form, clock, reset, 1'b1,
      (head_ff < SLOTS_LINK) || (head_ff == NULL_LINK), "head pointer out of range")
   `SLLI_ASSERT_SAME(a_write_ok, clock, reset, cmd.write_entry,
      !stat.slot_bad && !stat.value_bad, "rejected insert written to the table")
   `SLLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result beat changed or dropped")

endmodule

>>> design/sorted_index_linked_list_insert.sv
// Sorted slot list top level: controller and datapath.
//
// A table of SLOTS slots holds 8-bit values chained in ascending order from a
// head pointer. An insert (req_type 0) is checked for slot range, value limit
// (csr register, reset 100), slot already listed and duplicate value, then
// linked in place; it gives one result beat. A readout (req_type 1) gives one
// beat per listed entry, at most MAX_RESULTS, in ascending order with last on
// the final one, or a single beat with status empty. The walk visits one entry
// per cycle through the table's registered read port, and a readout holds its
// entry while the output register is busy. One request is worked at a time;
// the next beat is taken while the final result still waits in the output
// register.
module sorted_index_linked_list_insert
   import slli_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_beat_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_beat_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [VALUE_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // Request sequencing.
   slli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Tables and result path.
   slli_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
